>>> sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // Default geometry
    localparam int DEPTH_DEF         = 16;
    localparam int PRIORITY_BITS_DEF = 4;
    localparam int TAG_BITS_DEF      = 16;

    // Operation codes carried in mode
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Status codes
    localparam int            STATUS_BITS = 2;
    localparam logic [1:0]    ST_DONE     = 2'd0;
    localparam logic [1:0]    ST_FULL     = 2'd1;
    localparam logic [1:0]    ST_EMPTY    = 2'd2;

    // Per-cell control, from the count logic to one cell
    typedef struct packed {
        logic enq;   // accepted enqueue that fits
        logic deq;   // accepted dequeue of a held entry
        logic occ;   // cell holds an entry
        logic tail;  // cell is the first free slot
    } spq_cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/spq_if.sv
`default_nettype none

// Request channel: one operation per word
interface spq_req_if #(
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0]      payload_tag;

    modport source (output valid, mode, priority_req, payload_tag, input ready);
    modport sink   (input valid, mode, priority_req, payload_tag, output ready);
endinterface

// Response channel: one result word per request
interface spq_rsp_if #(
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
    parameter int OCC_BITS      = $clog2(spq_pkg::DEPTH_DEF + 1)
);
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::STATUS_BITS-1:0] status;
    logic [PRIORITY_BITS-1:0]     out_priority;
    logic [TAG_BITS-1:0]          out_tag;
    logic [OCC_BITS-1:0]          occupancy;

    modport source (output valid, status, out_priority, out_tag, occupancy, input ready);
    modport sink   (input valid, status, out_priority, out_tag, occupancy, output ready);
endinterface

`default_nettype wire

>>> sv/spq_cell.sv
`default_nettype none

module spq_cell #(
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire spq_pkg::spq_cell_ctrl_t  ctrl,
    input  wire logic [PRIORITY_BITS-1:0] new_pri,
    input  wire logic [TAG_BITS-1:0]      new_tag,
    input  wire logic                     left_lt,
    input  wire logic [PRIORITY_BITS-1:0] left_pri,
    input  wire logic [TAG_BITS-1:0]      left_tag,
    input  wire logic [PRIORITY_BITS-1:0] right_pri,
    input  wire logic [TAG_BITS-1:0]      right_tag,
    output logic [PRIORITY_BITS-1:0]      pri,
    output logic [TAG_BITS-1:0]           tag,
    output logic                          lt
);
    import spq_pkg::*;

    logic [PRIORITY_BITS-1:0] pri_reg, pri_next;
    logic [TAG_BITS-1:0]      tag_reg, tag_next;

    // Held entry loses to the new one: it moves one place towards the tail
    assign lt = ctrl.occ && (pri_reg < new_pri);

    // Enqueue: shifted cells take the left neighbour, the insert slot takes the new word.
    // Dequeue: every cell takes its right neighbour.
    always_comb
    begin
        pri_next = pri_reg;
        tag_next = tag_reg;
        if (ctrl.enq && (lt || ctrl.tail))
        begin
            pri_next = left_lt ? left_pri : new_pri;
            tag_next = left_lt ? left_tag : new_tag;
        end
        else if (ctrl.deq)
        begin
            pri_next = right_pri;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg <= pri_next;
        tag_reg <= tag_next;
    end

    assign pri = pri_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Sorted priority queue built as a row of DEPTH shift cells, head in cell 0.
// req channel: one word per operation; mode selects enqueue or dequeue,
// priority_req and payload_tag give the entry (ignored on dequeue).
// rsp channel: exactly one word per accepted request, in request order,
// carrying status (done, full, empty), the dequeued entry (zero otherwise)
// and the occupancy after the operation.
// An enqueue lands behind every entry of equal or higher priority; an
// enqueue into a full queue is dropped, a dequeue of an empty one is refused.
// The response word is registered and valid in the cycle after acceptance.
// Throughput: one request per cycle while rsp is not stalled; every cell
// compares and shifts in the same cycle, so the insert position does not slow it.
// Reset empties the queue (count to zero) and drops the response valid flag;
// cell contents are not cleared and are never shown before being written.
// When rsp stalls, the response register holds and req.ready drops until
// the response is taken; no request is lost or reordered.
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);
    import spq_pkg::*;

    localparam int OCC_BITS = $clog2(DEPTH + 1);

    logic [OCC_BITS-1:0]      count_reg, count_next;
    logic                     rsp_valid_reg;
    logic [STATUS_BITS-1:0]   status_reg, status_next;
    logic [PRIORITY_BITS-1:0] opri_reg, opri_next;
    logic [TAG_BITS-1:0]      otag_reg, otag_next;

    logic accept, full, empty, do_enq, do_deq;

    spq_cell_ctrl_t           ctrl [DEPTH];
    logic [PRIORITY_BITS-1:0] cell_pri [DEPTH];
    logic [TAG_BITS-1:0]      cell_tag [DEPTH];
    logic                     cell_lt [DEPTH];

    // Handshake and operation decode
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == OCC_BITS'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_enq    = accept && (req.mode == MODE_ENQ) && !full;
    assign do_deq    = accept && (req.mode == MODE_DEQ) && !empty;

    // Cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     l_lt;
        logic [PRIORITY_BITS-1:0] l_pri, r_pri;
        logic [TAG_BITS-1:0]      l_tag, r_tag;

        assign ctrl[i].enq  = do_enq;
        assign ctrl[i].deq  = do_deq;
        assign ctrl[i].occ  = (OCC_BITS'(i) < count_reg);
        assign ctrl[i].tail = (OCC_BITS'(i) == count_reg);

        if (i == 0)
        begin : g_head
            assign l_lt  = 1'b0;
            assign l_pri = '0;
            assign l_tag = '0;
        end
        else
        begin : g_mid
            assign l_lt  = cell_lt[i-1];
            assign l_pri = cell_pri[i-1];
            assign l_tag = cell_tag[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_pri = '0;
            assign r_tag = '0;
        end
        else
        begin : g_inner
            assign r_pri = cell_pri[i+1];
            assign r_tag = cell_tag[i+1];
        end

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .TAG_BITS      (TAG_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .new_pri   (req.priority_req),
            .new_tag   (req.payload_tag),
            .left_lt   (l_lt),
            .left_pri  (l_pri),
            .left_tag  (l_tag),
            .right_pri (r_pri),
            .right_tag (r_tag),
            .pri       (cell_pri[i]),
            .tag       (cell_tag[i]),
            .lt        (cell_lt[i])
        );
    end

    // Count and response word
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        opri_next   = opri_reg;
        otag_next   = otag_reg;
        if (accept)
        begin
            status_next = ST_DONE;
            opri_next   = '0;
            otag_next   = '0;
            unique case (req.mode)
                MODE_ENQ:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + OCC_BITS'(1);
                end
                MODE_DEQ:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        count_next = count_reg - OCC_BITS'(1);
                        opri_next  = cell_pri[0];
                        otag_next  = cell_tag[0];
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        opri_reg   <= opri_next;
        otag_reg   <= otag_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_priority = opri_reg;
    assign rsp.out_tag      = otag_reg;
    assign rsp.occupancy    = count_reg;

endmodule

`default_nettype wire

>>> sv/spq_check.sv
`default_nettype none

module spq_check #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic [spq_pkg::STATUS_BITS-1:0] status,
    input wire logic [PRIORITY_BITS-1:0]        out_priority,
    input wire logic [TAG_BITS-1:0]             out_tag,
    input wire logic [$clog2(DEPTH+1)-1:0]      occupancy
);
    import spq_pkg::*;

    localparam int OCC_BITS = $clog2(DEPTH + 1);

    // Every accepted word yields a response word in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no response after accepted request");

    // Full is reported only at full occupancy
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> occupancy == OCC_BITS'(DEPTH))
        else $error("full status below capacity");

    // Empty is reported only with nothing held and a zero entry
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |->
            occupancy == '0 && out_priority == '0 && out_tag == '0)
        else $error("empty status with entries or data");

    // Occupancy never exceeds capacity and status is a defined code
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> occupancy <= OCC_BITS'(DEPTH) &&
            (status == ST_DONE || status == ST_FULL || status == ST_EMPTY))
        else $error("bad occupancy or status");

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
            $stable(out_priority) && $stable(out_tag) && $stable(occupancy))
        else $error("stalled response changed");

endmodule

bind sorted_priority_queue spq_check #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TAG_BITS      (TAG_BITS)
) u_spq_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .out_priority (rsp.out_priority),
    .out_tag      (rsp.out_tag),
    .occupancy    (rsp.occupancy)
);

`default_nettype wire

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QDEPTH   = DEPTH_DEF;
    localparam int PRI_W    = PRIORITY_BITS_DEF;
    localparam int TAG_W    = TAG_BITS_DEF;
    localparam int OCC_W    = $clog2(DEPTH_DEF + 1);
    localparam int IDLE_MAX = 1000;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [PRI_W-1:0]       pri;
        logic [TAG_W-1:0]       tag;
        logic [OCC_W-1:0]       occ;
    } reply_t;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the queue contents, head at index 0
    logic [PRI_W-1:0] shadow_pri [QDEPTH];
    logic [TAG_W-1:0] shadow_tag [QDEPTH];
    int               shadow_count;

    reply_t       awaited_replies [$];
    int           words_sent;
    int           replies_seen;
    int           errors;
    int           full_refusals;
    int           empty_refusals;
    int           entries_popped;
    int           idle_cycles;

    // Sender pacing and receiver stall controls
    bit           pace_enable;
    int           burst_left;
    stall_style_t stall_style;
    int           hold_cycles_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one operation to the shadow queue and return the reply it causes
    function automatic reply_t shadow_queue_op(input logic m, input logic [PRI_W-1:0] p,
                                               input logic [TAG_W-1:0] t);
        reply_t r;
        int     pos;
        r.status = ST_DONE;
        r.pri    = '0;
        r.tag    = '0;
        if (m == MODE_ENQ)
        begin
            if (shadow_count >= QDEPTH)
            begin
                r.status = ST_FULL;
                full_refusals++;
            end
            else
            begin
                // new entry lands behind everything of equal or higher priority
                pos = shadow_count;
                while (pos > 0 && shadow_pri[pos-1] < p)
                begin
                    shadow_pri[pos] = shadow_pri[pos-1];
                    shadow_tag[pos] = shadow_tag[pos-1];
                    pos--;
                end
                shadow_pri[pos] = p;
                shadow_tag[pos] = t;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                r.status = ST_EMPTY;
                empty_refusals++;
            end
            else
            begin
                r.pri = shadow_pri[0];
                r.tag = shadow_tag[0];
                for (int k = 1; k < shadow_count; k++)
                begin
                    shadow_pri[k-1] = shadow_pri[k];
                    shadow_tag[k-1] = shadow_tag[k];
                end
                shadow_count--;
                entries_popped++;
            end
        end
        r.occ = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic bit field_matches(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Predict on each accepted request, then check each accepted reply
    always @(posedge clk)
    begin : scoreboard
        reply_t want;
        bit     ok;
        if (req_ch.valid && req_ch.ready)
            awaited_replies.push_back(shadow_queue_op(req_ch.mode, req_ch.priority_req,
                                                      req_ch.payload_tag));
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            replies_seen++;
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: reply with none expected, status %0d occupancy %0d",
                         $time, rsp_ch.status, rsp_ch.occupancy);
                errors++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                ok = field_matches("status", want.status, rsp_ch.status);
                ok = field_matches("out_priority", want.pri, rsp_ch.out_priority) && ok;
                ok = field_matches("out_tag", want.tag, rsp_ch.out_tag) && ok;
                ok = field_matches("occupancy", want.occ, rsp_ch.occupancy) && ok;
                if (!ok)
                    errors++;
            end
        end
    end

    // Watchdog: stretches with no handshake on either side
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_MAX)
        begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_MAX);
            $display("sorted_priority_queue: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Reply side: stall pattern per style, or a long hold-off when asked
    initial
    begin : reply_drive
        int hold_len;
        int tick;
        logic take;
        tick = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_cycles_req != 0)
            begin
                hold_len = hold_cycles_req;
                hold_cycles_req = 0;
                rsp_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else
            begin
                case (stall_style)
                    STALL_NONE:     take = 1'b1;
                    STALL_LIGHT:    take = ($urandom_range(0, 3) != 0);
                    STALL_HEAVY:    take = ($urandom_range(0, 3) == 0);
                    default:        take = ((tick % 7) < 4);
                endcase
                rsp_ch.ready <= take;
            end
        end
    end

    // Offer one word and return at the edge where it is taken
    task automatic send_word(input logic m, input logic [PRI_W-1:0] p,
                             input logic [TAG_W-1:0] t);
        int gap;
        if (pace_enable && burst_left <= 0)
        begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= m;
        req_ch.priority_req <= p;
        req_ch.payload_tag  <= t;
        do
            @(posedge clk);
        while (!req_ch.ready);
        words_sent++;
        burst_left--;
    endtask

    // Sender pauses until every reply is back
    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (replies_seen < words_sent)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Empty refusals, priority and tag extremes, ties leaving in arrival order
    task automatic test_extremes_and_ties();
        send_word(MODE_DEQ, '1, '1);
        send_word(MODE_DEQ, '0, '0);
        send_word(MODE_ENQ, 4'd0, 16'h0000);
        send_word(MODE_ENQ, 4'd15, 16'hFFFF);
        send_word(MODE_ENQ, 4'd7, 16'h1111);
        send_word(MODE_ENQ, 4'd7, 16'h2222);
        send_word(MODE_ENQ, 4'd15, 16'hAAAA);
        send_word(MODE_ENQ, 4'd0, 16'h5555);
        send_word(MODE_ENQ, 4'd7, 16'h3333);
        repeat (7)
            send_word(MODE_DEQ, PRI_W'($urandom_range(0, 15)), TAG_W'($urandom));
        send_word(MODE_DEQ, 4'd9, 16'h8001);
        wait_for_replies();
    endtask

    // Fill to the top, push past it, then drain past empty
    task automatic test_fill_overflow_drain();
        bit narrow;
        narrow = $urandom_range(0, 1);
        repeat (QDEPTH)
            send_word(MODE_ENQ, narrow ? PRI_W'($urandom_range(5, 6))
                                       : PRI_W'($urandom_range(0, 15)),
                      TAG_W'($urandom));
        send_word(MODE_ENQ, 4'd15, 16'hFFFF);
        send_word(MODE_ENQ, 4'd0, 16'h0000);
        send_word(MODE_ENQ, PRI_W'($urandom_range(0, 15)), TAG_W'($urandom));
        repeat (QDEPTH + 1)
            send_word(MODE_DEQ, PRI_W'($urandom_range(0, 15)), TAG_W'($urandom));
        wait_for_replies();
    endtask

    // Receiver holds off a long while; the sender keeps offering words
    task automatic test_reply_backpressure();
        pace_enable = 1'b0;
        stall_style = STALL_NONE;
        hold_cycles_req = 80;
        repeat (40)
            send_word(($urandom_range(0, 99) < 65) ? MODE_ENQ : MODE_DEQ,
                      PRI_W'($urandom_range(0, 15)), TAG_W'($urandom));
        wait_for_replies();
    endtask

    // Random phases: fill-heavy, drain-heavy and balanced, wide or tied priorities
    task automatic test_random_mix(input int phases);
        int   enq_pct;
        bit   narrow;
        int   lo;
        logic m;
        for (int ph = 0; ph < phases; ph++)
        begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 20;
                default: enq_pct = 55;
            endcase
            narrow      = ($urandom_range(0, 2) == 0);
            lo          = $urandom_range(0, 14);
            pace_enable = $urandom_range(0, 1);
            stall_style = stall_style_t'($urandom_range(0, 3));
            repeat (40)
            begin
                m = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
                send_word(m, narrow ? PRI_W'(lo + $urandom_range(0, 1))
                                    : PRI_W'($urandom_range(0, 15)),
                          TAG_W'($urandom));
            end
            if (ph % 5 == 4)
                wait_for_replies();
        end
        wait_for_replies();
    endtask

    initial
    begin : main
        shadow_count    = 0;
        words_sent      = 0;
        replies_seen    = 0;
        errors          = 0;
        full_refusals   = 0;
        empty_refusals  = 0;
        entries_popped  = 0;
        idle_cycles     = 0;
        pace_enable     = 1'b1;
        burst_left      = 0;
        stall_style     = STALL_LIGHT;
        hold_cycles_req = 0;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_ENQ;
        req_ch.priority_req <= '0;
        req_ch.payload_tag  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes_and_ties();
        test_fill_overflow_drain();
        test_reply_backpressure();
        test_random_mix(20);

        repeat (4) @(posedge clk);
        if (awaited_replies.size() != 0)
        begin
            $display("%0t: %0d replies never arrived", $time, awaited_replies.size());
            errors++;
        end
        $display("%0d requests and replies: %0d entries dequeued, %0d full drops, %0d empty",
                 words_sent, entries_popped, full_refusals, empty_refusals);
        $display("stall styles, a long reply hold-off and sender gaps were all exercised");
        if (errors == 0)
            $display("sorted_priority_queue: match");
        else
            $display("sorted_priority_queue: mismatch");
        $finish;
    end

endmodule
